>>> sv/fkg_pkg.sv
`timescale 1ns / 1ps
// Shared types for the fractional knapsack block: controller states and the
// command/status structs between controller and datapath. No dependencies.
package fkg_pkg;

   localparam int CostW  = 16;
   localparam int ValW   = 16;
   localparam int CapW   = 14;
   localparam int TotalW = 30;
   localparam int ProdW  = 32;
   localparam int QuotW  = 24;   // part < value * 256
   localparam int DivCntW = 5;
   localparam logic [DivCntW-1:0] DivSteps = 5'd24;
   localparam logic [7:0] FracZero = 8'h00;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ITEM,
      ST_INS_RD,
      ST_INS_MUL,
      ST_INS_CMP,
      ST_EVAL,
      ST_SC_RD,
      ST_SC_CHK,
      ST_DIV_INIT,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;       // capture request beat
      logic ins_new;    // write new item at insertion slot, bump count
      logic ins_shift;  // move read entry up one slot
      logic rd_ins;     // read entry below insertion slot
      logic mul_ins;    // cross products for density compare
      logic scan_init;  // clear greedy accumulators
      logic rd_scan;    // read sorted entry at scan index
      logic take;       // take whole item
      logic mul_part;   // value * remaining capacity
      logic div_init;
      logic div_step;
      logic emit_ok;
      logic emit_err;
   } cmd_type;

   typedef struct packed {
      logic j_zero;
      logic denser;
      logic drop;
      logic last;
      logic bad;
      logic scan_end;
      logic fits;
      logic div_last;
   } stat_type;

endpackage

>>> sv/fkg_ctrl.sv
`timescale 1ns / 1ps
// Controller for the fractional knapsack block: sequences insertion sort,
// greedy scan and the fractional divide. Depends on fkg_pkg.
module fkg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fkg_pkg::stat_type stat,
   output fkg_pkg::cmd_type  cmd
);

   fkg_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fkg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fkg_pkg::ST_IDLE:     if (start) state_in = fkg_pkg::ST_ITEM;
         fkg_pkg::ST_ITEM: begin
            if (stat.drop || stat.j_zero) begin
               state_in = stat.last ? fkg_pkg::ST_EVAL : fkg_pkg::ST_IDLE;
            end else begin
               state_in = fkg_pkg::ST_INS_RD;
            end
         end
         fkg_pkg::ST_INS_RD:   state_in = fkg_pkg::ST_INS_MUL;
         fkg_pkg::ST_INS_MUL:  state_in = fkg_pkg::ST_INS_CMP;
         fkg_pkg::ST_INS_CMP: begin
            if (stat.denser) begin
               state_in = fkg_pkg::ST_ITEM;
            end else begin
               state_in = stat.last ? fkg_pkg::ST_EVAL : fkg_pkg::ST_IDLE;
            end
         end
         fkg_pkg::ST_EVAL:     state_in = stat.bad ? fkg_pkg::ST_IDLE : fkg_pkg::ST_SC_RD;
         fkg_pkg::ST_SC_RD:    state_in = stat.scan_end ? fkg_pkg::ST_FIN : fkg_pkg::ST_SC_CHK;
         fkg_pkg::ST_SC_CHK:   state_in = stat.fits ? fkg_pkg::ST_SC_RD : fkg_pkg::ST_DIV_INIT;
         fkg_pkg::ST_DIV_INIT: state_in = fkg_pkg::ST_DIV;
         fkg_pkg::ST_DIV:      if (stat.div_last) state_in = fkg_pkg::ST_FIN;
         fkg_pkg::ST_FIN:      state_in = fkg_pkg::ST_IDLE;
         default:              state_in = fkg_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = (state_ff != fkg_pkg::ST_IDLE);
      unique case (state_ff)
         fkg_pkg::ST_IDLE:     cmd.load = start;
         fkg_pkg::ST_ITEM: begin
            if (!stat.drop) begin
               if (stat.j_zero) cmd.ins_new = 1'b1;
               else             cmd.rd_ins  = 1'b1;
            end
         end
         fkg_pkg::ST_INS_RD:   ;
         fkg_pkg::ST_INS_MUL:  cmd.mul_ins = 1'b1;
         fkg_pkg::ST_INS_CMP: begin
            if (stat.denser) cmd.ins_shift = 1'b1;
            else             cmd.ins_new   = 1'b1;
         end
         fkg_pkg::ST_EVAL: begin
            if (stat.bad) cmd.emit_err  = 1'b1;
            else          cmd.scan_init = 1'b1;
         end
         fkg_pkg::ST_SC_RD:    cmd.rd_scan = !stat.scan_end;
         fkg_pkg::ST_SC_CHK: begin
            if (stat.fits) cmd.take     = 1'b1;
            else           cmd.mul_part = 1'b1;
         end
         fkg_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
         fkg_pkg::ST_DIV:      cmd.div_step = 1'b1;
         fkg_pkg::ST_FIN:      cmd.emit_ok  = 1'b1;
         default:              ;
      endcase
   end

   // result leaves the sequencer idle
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_ok || cmd.emit_err) |=> (state_ff == fkg_pkg::ST_IDLE))
      else $error("emit not followed by idle");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("load while busy");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins_new && cmd.ins_shift))
      else $error("two writes in one cycle");

endmodule

>>> sv/fkg_dp.sv
`timescale 1ns / 1ps
// Datapath for the fractional knapsack block: sorted item memory, density
// compare, greedy accumulators, restoring divider, result register. Uses fkg_pkg.
module fkg_dp #(
   parameter int MAX_ITEMS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fkg_pkg::cmd_type            cmd,
   output fkg_pkg::stat_type           stat,
   input  logic [fkg_pkg::CostW-1:0]   req_item_cost,
   input  logic [fkg_pkg::ValW-1:0]    req_item_value,
   input  logic                        req_last_item,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fkg_pkg::CapW-1:0]    csr_wdata,
   output logic                        rsp_strobe,
   output logic [fkg_pkg::TotalW-1:0]  rsp_total_value,
   output logic                        rsp_status
);

   localparam int IdxW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CntW   = $clog2(MAX_ITEMS + 1);
   localparam int WholeW = fkg_pkg::ValW + CntW;
   localparam int TotW   = WholeW + 9;
   localparam int SumW   = (TotW > fkg_pkg::TotalW) ? TotW : fkg_pkg::TotalW + 1;
   localparam int EntW   = fkg_pkg::CostW + fkg_pkg::ValW;
   localparam int UsedW  = fkg_pkg::CapW + 3;

   // item memory, kept in descending density order
   logic [EntW-1:0] mem [MAX_ITEMS];

   logic [fkg_pkg::CostW-1:0]  new_cost_ff, rd_cost_ff;
   logic [fkg_pkg::ValW-1:0]   new_val_ff, rd_val_ff;
   logic                       last_ff, drop_ff;
   logic [IdxW-1:0]            j_ff;
   logic [CntW-1:0]            count_ff, count_in, i_ff;
   logic                       err_ff, err_in;
   logic [fkg_pkg::CapW-1:0]   cap_ff, used_ff, rem_cap;
   logic [fkg_pkg::ProdW-1:0]  lhs_ff, rhs_ff;
   logic [WholeW-1:0]          whole_ff;
   logic [fkg_pkg::CostW-1:0]  rem_ff, rem_in;
   logic [fkg_pkg::QuotW-1:0]  numer_ff;
   logic [fkg_pkg::DivCntW-1:0] dcnt_ff;
   logic [fkg_pkg::CostW:0]    r2, r2_sub;
   logic                       ge;
   logic [IdxW-1:0]            rd_addr;
   logic                       wr_en;
   logic [EntW-1:0]            wr_data;
   logic [UsedW-1:0]           used_sum;
   logic [SumW-1:0]            total;
   logic [fkg_pkg::TotalW-1:0] total_sat;
   logic                       full;

   assign csr_ready = 1'b1;
   assign full = (count_ff == CntW'(MAX_ITEMS));

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else if (csr_valid) begin
         cap_ff <= csr_wdata;
      end
   end

   // set bookkeeping
   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      if (cmd.load) begin
         err_in = err_ff | full | (req_item_cost == '0);
      end
      if (cmd.ins_new) count_in = count_ff + CntW'(1);
      if (cmd.emit_ok || cmd.emit_err) begin
         count_in = '0;
         err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   // request capture and insertion slot
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_cost_ff <= req_item_cost;
         new_val_ff  <= req_item_value;
         last_ff     <= req_last_item;
         drop_ff     <= full;
         j_ff        <= count_ff[IdxW-1:0];
      end else if (cmd.ins_shift) begin
         j_ff <= j_ff - IdxW'(1);
      end
   end

   // memory ports
   assign rd_addr = cmd.rd_scan ? i_ff[IdxW-1:0] : (j_ff - IdxW'(1));
   assign wr_en   = cmd.ins_new || cmd.ins_shift;
   assign wr_data = cmd.ins_new ? {new_cost_ff, new_val_ff} : {rd_cost_ff, rd_val_ff};

   always_ff @(posedge clock) begin
      if (wr_en) mem[j_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_ins || cmd.rd_scan) {rd_cost_ff, rd_val_ff} <= mem[rd_addr];
   end

   // products: density cross products, or value * remaining capacity
   assign rem_cap = cap_ff - used_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul_ins) begin
         lhs_ff <= new_val_ff * rd_cost_ff;
         rhs_ff <= rd_val_ff * new_cost_ff;
      end else if (cmd.mul_part) begin
         lhs_ff <= fkg_pkg::ProdW'(rd_val_ff) * fkg_pkg::ProdW'(rem_cap);
      end
   end

   // greedy accumulators
   assign used_sum = UsedW'(used_ff) + UsedW'(rd_cost_ff);
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         i_ff     <= '0;
         used_ff  <= '0;
         whole_ff <= '0;
         numer_ff <= '0;
      end else begin
         if (cmd.take) begin
            i_ff     <= i_ff + CntW'(1);
            used_ff  <= used_sum[fkg_pkg::CapW-1:0];
            whole_ff <= whole_ff + WholeW'(rd_val_ff);
         end
         if (cmd.div_init) begin
            numer_ff <= {lhs_ff[15:0], fkg_pkg::FracZero};
         end else if (cmd.div_step) begin
            numer_ff <= {numer_ff[fkg_pkg::QuotW-2:0], ge};
         end
      end
   end

   // restoring divider, one quotient bit a cycle
   assign r2     = {rem_ff, numer_ff[fkg_pkg::QuotW-1]};
   assign r2_sub = r2 - {1'b0, rd_cost_ff};
   assign ge     = (r2 >= {1'b0, rd_cost_ff});
   assign rem_in = ge ? r2_sub[fkg_pkg::CostW-1:0] : r2[fkg_pkg::CostW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= {2'b00, lhs_ff[29:16]};
         dcnt_ff <= fkg_pkg::DivSteps;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         dcnt_ff <= dcnt_ff - fkg_pkg::DivCntW'(1);
      end
   end

   // total with saturation
   assign total     = SumW'({whole_ff, fkg_pkg::FracZero}) + SumW'(numer_ff);
   assign total_sat = (|total[SumW-1:fkg_pkg::TotalW]) ? '1 : total[fkg_pkg::TotalW-1:0];

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.emit_ok || cmd.emit_err;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         rsp_total_value <= '0;
         rsp_status      <= fkg_pkg::STATUS_ERR;
      end else if (cmd.emit_ok) begin
         rsp_total_value <= total_sat;
         rsp_status      <= fkg_pkg::STATUS_OK;
      end
   end

   // status to controller
   assign stat.j_zero   = (j_ff == '0);
   assign stat.denser   = (lhs_ff > rhs_ff);
   assign stat.drop     = drop_ff;
   assign stat.last     = last_ff;
   assign stat.bad      = err_ff || (cap_ff == '0);
   assign stat.scan_end = (i_ff == count_ff);
   assign stat.fits     = (used_sum <= UsedW'(cap_ff));
   assign stat.div_last = (dcnt_ff == fkg_pkg::DivCntW'(1));

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_ITEMS))
      else $error("item count beyond store depth");
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result beats in a row");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == fkg_pkg::STATUS_ERR) |-> (rsp_total_value == '0))
      else $error("error beat with nonzero total");

endmodule

>>> sv/fractional_knapsack_greedy.sv
`timescale 1ns / 1ps
// Fractional knapsack, greedy by value density: top level.
// Depends on fkg_pkg, fkg_ctrl, fkg_dp.
//
// Usage: write the capacity on the csr_ channel (always ready) while idle.
// Present one item per beat on req_item_cost / req_item_value with start;
// an item is taken at a clock edge with start high and busy low. The beat
// with req_last_item high closes the set and produces one result beat:
// rsp_strobe high for exactly one cycle with rsp_total_value (8 fraction
// bits, truncated, saturated) and rsp_status (1 on zero capacity, zero
// cost or too many items). The receiver cannot stall; the result is lost
// if not sampled in that cycle.
// Timing: each item is inserted into the sorted store as it arrives,
// walking down past each less dense entry with a read, a multiply and a
// compare per entry compared; busy stays high until the item is placed,
// so the next item waits. The last item then goes through evaluate, the
// greedy scan (a read and a check per item taken), for a partly taken item
// a read and a check plus the divider (setup and 24 quotient bits), the
// finish state, and the result beat in the cycle after. An error set gives
// its result beat in the cycle after evaluate.
// Reset clears the set, the capacity and the result strobe; the store is
// not cleared, only entries written in the current set are read.
module fractional_knapsack_greedy #(
   parameter int MAX_ITEMS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [fkg_pkg::CostW-1:0]   req_item_cost,
   input  logic [fkg_pkg::ValW-1:0]    req_item_value,
   input  logic                        req_last_item,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fkg_pkg::CapW-1:0]    csr_wdata,
   output logic                        rsp_strobe,
   output logic [fkg_pkg::TotalW-1:0]  rsp_total_value,
   output logic                        rsp_status
);

   fkg_pkg::cmd_type  cmd;
   fkg_pkg::stat_type stat;

   // sequencer
   fkg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // datapath
   fkg_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_item_cost   (req_item_cost),
      .req_item_value  (req_item_value),
      .req_last_item   (req_last_item),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_total_value (rsp_total_value),
      .rsp_status      (rsp_status)
   );

endmodule

>>> bench/fractional_knapsack_greedy_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fractional_knapsack_greedy: directed and random item
// sets with an in-bench greedy knapsack predictor. Depends on fkg_pkg and the RTL.
module fractional_knapsack_greedy_tb;

   localparam int MaxItems  = 32;
   localparam int SettleCyc = 300;
   localparam int WatchLim  = 20000;
   localparam int PhaseItems = 350;
   localparam logic [fkg_pkg::TotalW-1:0] TotalMax = '1;

   typedef struct {
      logic [fkg_pkg::TotalW-1:0] total;
      logic                       status;
   } outcome_type;

   typedef struct {
      bit                         wr_cap;
      logic [fkg_pkg::CapW-1:0]   cap;
      logic [fkg_pkg::CostW-1:0]  cost;
      logic [fkg_pkg::ValW-1:0]   value;
      logic                       last;
      bit                         typed;
      logic [fkg_pkg::TotalW-1:0] total;
      logic                       status;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [fkg_pkg::CostW-1:0]  req_item_cost = '0;
   logic [fkg_pkg::ValW-1:0]   req_item_value = '0;
   logic                       req_last_item = 1'b0;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [fkg_pkg::CapW-1:0]   csr_wdata = '0;
   logic                       rsp_strobe;
   logic [fkg_pkg::TotalW-1:0] rsp_total_value;
   logic                       rsp_status;

   // predictor copy of the block state
   logic [fkg_pkg::CostW-1:0] set_cost [MaxItems];
   logic [fkg_pkg::ValW-1:0]  set_value [MaxItems];
   int                        set_count = 0;
   bit                        set_bad = 0;
   logic [fkg_pkg::CapW-1:0]  budget = '0;

   outcome_type totals_due[$];
   int          errors = 0;
   int          quiet_cycles = 0;
   int          idle_pct = 0;
   int          items_sent = 0;

   fractional_knapsack_greedy #(.MAX_ITEMS(MaxItems)) uut (.*);

   always #5 clock = ~clock;

   // greedy fill of the stored set, densest first, ties in arrival order
   function automatic logic [fkg_pkg::TotalW-1:0] knapsack_total();
      int order [MaxItems];
      int key, j;
      longint unsigned whole, used, part, total, c, v;
      whole = 0;
      used = 0;
      part = 0;
      for (int i = 0; i < set_count; i++) order[i] = i;
      for (int i = 1; i < set_count; i++) begin
         key = order[i];
         j = i;
         while (j > 0 && longint'(set_value[key]) * set_cost[order[j-1]] >
                         longint'(set_value[order[j-1]]) * set_cost[key]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = key;
      end
      for (int i = 0; i < set_count; i++) begin
         c = set_cost[order[i]];
         v = set_value[order[i]];
         if (used + c <= budget) begin
            whole += v;
            used += c;
         end else begin
            if (c != 0) part = (v * (budget - used) * 256) / c;
            break;
         end
      end
      total = whole * 256 + part;
      return (total > TotalMax) ? TotalMax : total[fkg_pkg::TotalW-1:0];
   endfunction

   // one accepted item beat; returns 1 with the outcome when the set closes
   function automatic bit absorb_item(input logic [fkg_pkg::CostW-1:0] cost,
                                      input logic [fkg_pkg::ValW-1:0] value,
                                      input logic last, output outcome_type res);
      if (set_count >= MaxItems) set_bad = 1;
      else begin
         set_cost[set_count] = cost;
         set_value[set_count] = value;
         set_count++;
         if (cost == 0) set_bad = 1;
      end
      if (!last) return 0;
      if (set_bad || budget == 0) begin
         res.total = '0;
         res.status = fkg_pkg::STATUS_ERR;
      end else begin
         res.total = knapsack_total();
         res.status = fkg_pkg::STATUS_OK;
      end
      set_count = 0;
      set_bad = 0;
      return 1;
   endfunction

   // drive one item until accepted; start stays high into the next item
   task automatic send_item(input logic [fkg_pkg::CostW-1:0] cost,
                            input logic [fkg_pkg::ValW-1:0] value,
                            input logic last, input bit typed,
                            input outcome_type typed_res);
      outcome_type res;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start = 1'b1;
      req_item_cost = cost;
      req_item_value = value;
      req_last_item = last;
      while (busy) @(negedge clock);
      @(posedge clock);
      items_sent++;
      if (absorb_item(cost, value, last, res)) totals_due.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   // wait for the block to drain, then write the capacity
   task automatic write_budget(input logic [fkg_pkg::CapW-1:0] cap);
      start = 1'b0;
      wait (totals_due.size() == 0);
      @(negedge clock);
      repeat (SettleCyc) @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = cap;
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      budget = cap;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_set();
      int len, cmax, pick;
      logic [fkg_pkg::CostW-1:0] cost;
      outcome_type none;
      none = '{default: '0};
      pick = $urandom_range(99);
      len = (pick < 5) ? $urandom_range(33, 35) :
            (pick < 20) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      cmax = (budget < 16) ? 16 : int'(budget) / 2;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         cost = (pick < 3) ? '0 : (pick < 15) ? fkg_pkg::CostW'($urandom) :
                fkg_pkg::CostW'($urandom_range(1, cmax));
         send_item(cost, fkg_pkg::ValW'($urandom), i == len - 1, 0, none);
      end
   endtask

   // result beats against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (totals_due.size() == 0) begin
            $error("unexpected result beat: total_value %0d status %0d",
                   rsp_total_value, rsp_status);
            errors++;
         end else begin
            if (rsp_total_value !== totals_due[0].total) begin
               $error("total_value expected %0d actual %0d", totals_due[0].total,
                      rsp_total_value);
               errors++;
            end
            if (rsp_status !== totals_due[0].status) begin
               $error("status expected %0d actual %0d", totals_due[0].status, rsp_status);
               errors++;
            end
            void'(totals_due.pop_front());
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLim) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      outcome_type typed_res;
      int phase_pct [4];
      logic [fkg_pkg::CapW-1:0] phase_cap [4];
      int sent;
      phase_pct = '{0, 50, 0, 34};
      phase_cap = '{16383, 1, 0, 40};
      phase_cap[2] = fkg_pkg::CapW'($urandom_range(1, 16383));
      // zero capacity from reset, then extremes, ties and error cases
      rows = '{
         '{0, 0,     5,     10,    1, 1, 0,        fkg_pkg::STATUS_ERR},
         '{1, 16383, 0,     7,     1, 1, 0,        fkg_pkg::STATUS_ERR},
         '{0, 0,     65535, 65535, 1, 1, 4194048,  fkg_pkg::STATUS_OK},
         '{0, 0,     1,     65535, 1, 1, 16776960, fkg_pkg::STATUS_OK},
         '{0, 0,     65535, 0,     1, 1, 0,        fkg_pkg::STATUS_OK},
         '{0, 0,     2,     4,     0, 0, 0,        fkg_pkg::STATUS_OK},
         '{0, 0,     1,     2,     0, 0, 0,        fkg_pkg::STATUS_OK},
         '{0, 0,     3,     6,     0, 0, 0,        fkg_pkg::STATUS_OK},
         '{0, 0,     16383, 1,     1, 0, 0,        fkg_pkg::STATUS_OK},
         '{1, 1,     2,     65535, 1, 1, 8388480,  fkg_pkg::STATUS_OK},
         '{1, 10,    4,     8,     0, 0, 0,        fkg_pkg::STATUS_OK},
         '{0, 0,     4,     12,    0, 0, 0,        fkg_pkg::STATUS_OK},
         '{0, 0,     4,     4,     1, 0, 0,        fkg_pkg::STATUS_OK},
         '{0, 0,     0,     5,     0, 1, 0,        fkg_pkg::STATUS_ERR},
         '{0, 0,     3,     3,     1, 1, 0,        fkg_pkg::STATUS_ERR}
      };
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (rows[i]) begin
         if (rows[i].wr_cap) write_budget(rows[i].cap);
         typed_res.total = rows[i].total;
         typed_res.status = rows[i].status;
         send_item(rows[i].cost, rows[i].value, rows[i].last, rows[i].typed, typed_res);
      end
      // random sets across sender idling phases and capacities
      for (int p = 0; p < 4; p++) begin
         write_budget(phase_cap[p]);
         idle_pct = phase_pct[p];
         sent = items_sent;
         while (items_sent - sent < PhaseItems) begin
            random_set();
         end
      end
      start = 1'b0;
      wait (totals_due.size() == 0);
      repeat (SettleCyc) @(posedge clock);
      if (errors == 0 && totals_due.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
